// File: hdl/tca_pkg.sv
package tca_pkg;

    localparam int SQ_W         = 32;
    localparam int DIFF_W       = 16;
    localparam int N_W          = 34;
    localparam int P_W          = 64;
    localparam int R_W          = 32;
    localparam int H_W          = 5;
    localparam int NUM_W        = 50;
    localparam int Q_W          = 18;
    localparam int QC_W         = 17;
    localparam int C_W          = 18;
    localparam int YIN_W        = 34;
    localparam int Y_W          = 17;
    localparam int X_W          = 20;
    localparam int Z_W          = 26;
    localparam int ANG_W        = 16;
    localparam int CORDIC_STEPS = 17;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QA_W         = 2;

    localparam int ONE_Q16      = 65536;
    localparam int DEG90_Q16    = 5898240;
    localparam int ANGLE_MAX    = 46080;
    localparam int ANGLE_RIGHT  = 23040;
    localparam int DIFF_LIMIT   = 32767;

    typedef struct packed {
        logic            degen;
        logic [SQ_W-1:0] la;
        logic [SQ_W-1:0] lb;
        logic [SQ_W-1:0] lc;
    } t_sides;

    typedef struct packed {
        logic degen;
        logic right;
    } t_ctag;

    // arctangent of 2^-i in Q16 degrees
    function automatic logic signed [Z_W-1:0] atan_q16(input int idx);
        logic signed [Z_W-1:0] v;
        unique case (idx)
            0:       v = Z_W'(2949120);
            1:       v = Z_W'(1740967);
            2:       v = Z_W'(919879);
            3:       v = Z_W'(466945);
            4:       v = Z_W'(234379);
            5:       v = Z_W'(117304);
            6:       v = Z_W'(58666);
            7:       v = Z_W'(29335);
            8:       v = Z_W'(14668);
            9:       v = Z_W'(7334);
            10:      v = Z_W'(3667);
            11:      v = Z_W'(1833);
            12:      v = Z_W'(917);
            13:      v = Z_W'(458);
            14:      v = Z_W'(229);
            15:      v = Z_W'(115);
            16:      v = Z_W'(57);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/triangle_corner_angles.sv
// Throughput: one triangle per cycle unless stalled by o_full or a result awaiting pop;
// the front, side queue and corner pipeline are fully pipelined (root, divide and CORDIC
// units each retire one bit or step a stage).
// A four-entry queue lets the front keep taking items while the back is held by pop.
// Reset (synchronous, active low) clears all valid bits, pointers and counts.
module triangle_corner_angles #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic signed [COORD_WIDTH-1:0] i_p1_x,
    input  logic signed [COORD_WIDTH-1:0] i_p1_y,
    input  logic signed [COORD_WIDTH-1:0] i_p1_z,
    input  logic signed [COORD_WIDTH-1:0] i_p2_x,
    input  logic signed [COORD_WIDTH-1:0] i_p2_y,
    input  logic signed [COORD_WIDTH-1:0] i_p2_z,
    input  logic signed [COORD_WIDTH-1:0] i_p3_x,
    input  logic signed [COORD_WIDTH-1:0] i_p3_y,
    input  logic signed [COORD_WIDTH-1:0] i_p3_z,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic [15:0]                   o_angle_one,
    output logic [15:0]                   o_angle_two,
    output logic [15:0]                   o_angle_three,
    output logic                          o_degenerate
);

    logic            w_q_full;
    logic            w_q_push;
    logic            w_q_empty;
    logic            w_q_pop;
    tca_pkg::t_sides w_sides;
    tca_pkg::t_sides w_head;

    tca_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .o_full   (o_full),
        .i_p1_x   (i_p1_x),
        .i_p1_y   (i_p1_y),
        .i_p1_z   (i_p1_z),
        .i_p2_x   (i_p2_x),
        .i_p2_y   (i_p2_y),
        .i_p2_z   (i_p2_z),
        .i_p3_x   (i_p3_x),
        .i_p3_y   (i_p3_y),
        .i_p3_z   (i_p3_z),
        .i_q_full (w_q_full),
        .o_q_push (w_q_push),
        .o_sides  (w_sides)
    );

    tca_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_sides),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_head),
        .o_empty (w_q_empty)
    );

    tca_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_q_empty     (w_q_empty),
        .o_q_pop       (w_q_pop),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_angle_one   (o_angle_one),
        .o_angle_two   (o_angle_two),
        .o_angle_three (o_angle_three),
        .o_degenerate  (o_degenerate)
    );

    a_degen_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_degenerate) |->
        (o_angle_one == '0 && o_angle_two == '0 && o_angle_three == '0))
        else $error("degenerate result carries a non-zero angle");

    a_angle_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_angle_one <= 16'(tca_pkg::ANGLE_MAX)
                   && o_angle_two <= 16'(tca_pkg::ANGLE_MAX)
                   && o_angle_three <= 16'(tca_pkg::ANGLE_MAX)))
        else $error("angle above 180 degrees");

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty)
        else $error("result shown straight after reset");

    a_result_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=>
        (!o_empty && $stable(o_angle_one) && $stable(o_degenerate)))
        else $error("waiting result changed before transfer");

endmodule

// File: hdl/tca_front.sv
module tca_front #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic signed [COORD_WIDTH-1:0] i_p1_x,
    input  logic signed [COORD_WIDTH-1:0] i_p1_y,
    input  logic signed [COORD_WIDTH-1:0] i_p1_z,
    input  logic signed [COORD_WIDTH-1:0] i_p2_x,
    input  logic signed [COORD_WIDTH-1:0] i_p2_y,
    input  logic signed [COORD_WIDTH-1:0] i_p2_z,
    input  logic signed [COORD_WIDTH-1:0] i_p3_x,
    input  logic signed [COORD_WIDTH-1:0] i_p3_y,
    input  logic signed [COORD_WIDTH-1:0] i_p3_z,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output tca_pkg::t_sides               o_sides
);

    localparam int W    = COORD_WIDTH;
    localparam int SMAX = W;
    localparam int SW   = $clog2(SMAX + 1);
    localparam int DW   = (W + 1 > 17) ? W + 1 : 17;

    logic signed [W-1:0] w_in [0:8];
    logic                w_en;
    logic                w_deg;
    logic [4:0]          r_val;
    logic [3:0]          r_deg;

    logic signed [W-1:0] r_c0 [0:8];
    logic signed [W-1:0] r_c1 [0:8];
    logic [SW-1:0]       r_s1;
    logic [SMAX:0]       w_fits;
    logic [SW-1:0]       w_s;

    logic signed [W-1:0]                 w_w  [0:8];
    logic signed [tca_pkg::DIFF_W-1:0]   w_d  [0:8];
    logic signed [tca_pkg::DIFF_W-1:0]   r_d  [0:8];
    logic signed [tca_pkg::SQ_W-1:0]     w_p  [0:8];
    logic [tca_pkg::SQ_W-1:0]            r_sq [0:8];

    assign w_in[0] = i_p1_x;
    assign w_in[1] = i_p1_y;
    assign w_in[2] = i_p1_z;
    assign w_in[3] = i_p2_x;
    assign w_in[4] = i_p2_y;
    assign w_in[5] = i_p2_z;
    assign w_in[6] = i_p3_x;
    assign w_in[7] = i_p3_y;
    assign w_in[8] = i_p3_z;

    // hold every stage while the last one waits on a full queue
    assign w_en     = !(r_val[4] && i_q_full);
    assign o_full   = !w_en;
    assign o_q_push = r_val[4] && !i_q_full;

    assign w_deg = (w_in[0] == w_in[3] && w_in[1] == w_in[4] && w_in[2] == w_in[5])
                || (w_in[3] == w_in[6] && w_in[4] == w_in[7] && w_in[5] == w_in[8])
                || (w_in[6] == w_in[0] && w_in[7] == w_in[1] && w_in[8] == w_in[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
        end else if (w_en) begin
            r_val <= {r_val[3:0], i_push};
        end
    end

    // smallest shift that brings every edge component within range
    always_comb begin
        logic signed [W-1:0]  a;
        logic signed [W-1:0]  b;
        logic signed [DW-1:0] d;
        w_fits = '1;
        for (int s = 0; s <= SMAX; s++) begin
            for (int p = 0; p < 3; p++) begin
                for (int k = 0; k < 3; k++) begin
                    a = r_c0[p * 3 + k] >>> s;
                    b = r_c0[((p + 1) % 3) * 3 + k] >>> s;
                    d = DW'(a) - DW'(b);
                    if (d > tca_pkg::DIFF_LIMIT || d < -tca_pkg::DIFF_LIMIT) begin
                        w_fits[s] = 1'b0;
                    end
                end
            end
        end
        w_s = SW'(SMAX);
        for (int s = SMAX; s >= 0; s--) begin
            if (w_fits[s]) begin
                w_s = SW'(s);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            w_w[i] = r_c1[i] >>> r_s1;
        end
        for (int p = 0; p < 3; p++) begin
            for (int k = 0; k < 3; k++) begin
                w_d[p * 3 + k] = tca_pkg::DIFF_W'(DW'(w_w[p * 3 + k])
                                 - DW'(w_w[((p + 1) % 3) * 3 + k]));
            end
        end
        for (int i = 0; i < 9; i++) begin
            w_p[i] = r_d[i] * r_d[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c0     <= w_in;
            r_deg[0] <= w_deg;
            r_c1     <= r_c0;
            r_s1     <= w_s;
            r_deg[1] <= r_deg[0];
            r_d      <= w_d;
            r_deg[2] <= r_deg[1];
            for (int i = 0; i < 9; i++) begin
                r_sq[i] <= $unsigned(w_p[i]);
            end
            r_deg[3]      <= r_deg[2];
            o_sides.la    <= r_sq[0] + r_sq[1] + r_sq[2];
            o_sides.lb    <= r_sq[3] + r_sq[4] + r_sq[5];
            o_sides.lc    <= r_sq[6] + r_sq[7] + r_sq[8];
            o_sides.degen <= r_deg[3];
        end
    end

endmodule

// File: hdl/tca_queue.sv
module tca_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tca_pkg::t_sides i_data,
    output logic            o_full,
    input  logic            i_pop,
    output tca_pkg::t_sides o_data,
    output logic            o_empty
);

    tca_pkg::t_sides              r_mem [0:tca_pkg::QUEUE_DEPTH-1];
    logic [tca_pkg::QA_W-1:0]     r_wr;
    logic [tca_pkg::QA_W-1:0]     r_rd;
    logic [tca_pkg::QA_W:0]       r_cnt;

    assign o_full  = (r_cnt == (tca_pkg::QA_W + 1)'(tca_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// File: hdl/tca_isqrt.sv
module tca_isqrt #(
    parameter int IN_W = 64,
    parameter int PW   = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [IN_W-1:0]   i_val,
    input  logic [PW-1:0]     i_pay,
    output logic              o_valid,
    output logic [IN_W/2-1:0] o_root,
    output logic [PW-1:0]     o_pay
);

    localparam int OW = IN_W / 2;
    localparam int RW = OW + 3;

    logic [RW-1:0]   w_rem  [0:OW];
    logic [OW-1:0]   w_root [0:OW];
    logic [IN_W-1:0] w_rest [0:OW];
    logic [PW-1:0]   w_pay  [0:OW];
    logic [OW:0]     w_vld;

    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_rest[0] = i_val;
    assign w_pay[0]  = i_pay;
    assign w_vld[0]  = i_valid;

    // one result bit per stage, digit by digit
    for (genvar k = 0; k < OW; k++) begin : g_step
        logic [RW-1:0]   w_r2;
        logic [RW-1:0]   w_tr;
        logic            w_ge;
        logic [RW-1:0]   r_rem;
        logic [OW-1:0]   r_root;
        logic [IN_W-1:0] r_rest;
        logic [PW-1:0]   r_pay;
        logic            r_vld;

        assign w_r2 = {w_rem[k][RW-3:0], w_rest[k][IN_W-1 -: 2]};
        assign w_tr = {1'b0, w_root[k], 2'b01};
        assign w_ge = (w_r2 >= w_tr);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= w_ge ? (w_r2 - w_tr) : w_r2;
                r_root <= {w_root[k][OW-2:0], w_ge};
                r_rest <= {w_rest[k][IN_W-3:0], 2'b00};
                r_pay  <= w_pay[k];
            end
        end

        assign w_rem[k+1]  = r_rem;
        assign w_root[k+1] = r_root;
        assign w_rest[k+1] = r_rest;
        assign w_pay[k+1]  = r_pay;
        assign w_vld[k+1]  = r_vld;
    end

    assign o_valid = w_vld[OW];
    assign o_root  = w_root[OW];
    assign o_pay   = w_pay[OW];

endmodule

// File: hdl/tca_corner.sv
module tca_corner (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic                        i_degen,
    input  logic [tca_pkg::SQ_W-1:0]    i_opp,
    input  logic [tca_pkg::SQ_W-1:0]    i_s1,
    input  logic [tca_pkg::SQ_W-1:0]    i_s2,
    output logic                        o_valid,
    output logic                        o_degen,
    output logic [tca_pkg::ANG_W-1:0]   o_angle
);

    localparam int N_W   = tca_pkg::N_W;
    localparam int P_W   = tca_pkg::P_W;
    localparam int R_W   = tca_pkg::R_W;
    localparam int H_W   = tca_pkg::H_W;
    localparam int Q_W   = tca_pkg::Q_W;
    localparam int C_W   = tca_pkg::C_W;
    localparam int X_W   = tca_pkg::X_W;
    localparam int Z_W   = tca_pkg::Z_W;
    localparam int NSTEP = tca_pkg::CORDIC_STEPS;
    localparam int P1_W  = 3 + N_W + H_W;
    localparam int P2_W  = 3 + C_W;

    // input stage: numerator and product
    logic signed [N_W-1:0] w_n;
    logic                  r_a_vld;
    tca_pkg::t_ctag        r_a_tag;
    logic                  r_a_neg;
    logic [N_W-1:0]        r_a_mag;
    logic [P_W-1:0]        r_a_p;

    assign w_n = $signed({2'b00, i_s1}) + $signed({2'b00, i_s2}) - $signed({2'b00, i_opp});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_tag.degen <= i_degen;
            r_a_tag.right <= (i_s1 == '0) || (i_s2 == '0);
            r_a_neg       <= w_n[N_W-1];
            r_a_mag       <= w_n[N_W-1] ? $unsigned(-w_n) : $unsigned(w_n);
            r_a_p         <= P_W'(i_s1) * P_W'(i_s2);
        end
    end

    // normalise the product by whole bytes, then by bit pairs
    logic [2:0]      w_top;
    logic [2:0]      w_k8;
    logic            r_b_vld;
    tca_pkg::t_ctag  r_b_tag;
    logic            r_b_neg;
    logic [N_W-1:0]  r_b_mag;
    logic [P_W-1:0]  r_b_p;
    logic [H_W-1:0]  r_b_h;

    always_comb begin
        w_top = '0;
        for (int j = 0; j < 8; j++) begin
            if (r_a_p[8 * j +: 8] != '0) begin
                w_top = 3'(j);
            end
        end
        w_k8 = 3'd7 - w_top;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_tag <= r_a_tag;
            r_b_neg <= r_a_neg;
            r_b_mag <= r_a_mag;
            r_b_p   <= r_a_p << {w_k8, 3'b000};
            r_b_h   <= {w_k8, 2'b00};
        end
    end

    logic [1:0]      w_f2;
    logic            r_c_vld;
    logic [P1_W-1:0] r_c_pay;
    logic [P_W-1:0]  r_c_p;

    always_comb begin
        if (r_b_p[63:62] != '0) begin
            w_f2 = 2'd0;
        end else if (r_b_p[61:60] != '0) begin
            w_f2 = 2'd1;
        end else if (r_b_p[59:58] != '0) begin
            w_f2 = 2'd2;
        end else begin
            w_f2 = 2'd3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_p   <= r_b_p << {w_f2, 1'b0};
            r_c_pay <= {r_b_tag, r_b_neg, r_b_mag, r_b_h + H_W'(w_f2)};
        end
    end

    // root of the normalised product
    logic            w_s1_vld;
    logic [R_W-1:0]  w_root;
    logic [P1_W-1:0] w_s1_pay;

    tca_isqrt #(
        .IN_W (P_W),
        .PW   (P1_W)
    ) u_sqrt_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_c_vld),
        .i_val   (r_c_p),
        .i_pay   (r_c_pay),
        .o_valid (w_s1_vld),
        .o_root  (w_root),
        .o_pay   (w_s1_pay)
    );

    tca_pkg::t_ctag  w_s1_tag;
    logic            w_s1_neg;
    logic [N_W-1:0]  w_s1_mag;
    logic [H_W-1:0]  w_s1_h;

    assign {w_s1_tag, w_s1_neg, w_s1_mag, w_s1_h} = w_s1_pay;

    // dividend with the rounding half-divisor folded in
    logic                         r_n_vld;
    logic [tca_pkg::NUM_W-1:0]    r_n_num;
    logic [R_W-1:0]               r_n_r;
    tca_pkg::t_ctag               r_n_tag;
    logic                         r_n_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_vld <= 1'b0;
        end else if (i_en) begin
            r_n_vld <= w_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n_num <= (tca_pkg::NUM_W'(w_s1_mag) << (6'd15 + 6'(w_s1_h)))
                     + tca_pkg::NUM_W'(w_root >> 1);
            r_n_r   <= w_root;
            r_n_tag <= w_s1_tag;
            r_n_neg <= w_s1_neg;
        end
    end

    // restoring division, one quotient bit per stage
    logic [R_W-1:0]       w_drem [0:Q_W];
    logic [Q_W-1:0]       w_dlow [0:Q_W];
    logic [Q_W-1:0]       w_dq   [0:Q_W];
    logic [R_W-1:0]       w_dr   [0:Q_W];
    tca_pkg::t_ctag       w_dtag [0:Q_W];
    logic [Q_W:0]         w_dneg;
    logic [Q_W:0]         w_dvld;

    assign w_drem[0] = r_n_num[tca_pkg::NUM_W-1:Q_W];
    assign w_dlow[0] = r_n_num[Q_W-1:0];
    assign w_dq[0]   = '0;
    assign w_dr[0]   = r_n_r;
    assign w_dtag[0] = r_n_tag;
    assign w_dneg[0] = r_n_neg;
    assign w_dvld[0] = r_n_vld;

    for (genvar k = 0; k < Q_W; k++) begin : g_div
        logic [R_W:0]    w_t;
        logic            w_ge;
        logic [R_W-1:0]  r_rem;
        logic [Q_W-1:0]  r_low;
        logic [Q_W-1:0]  r_q;
        logic [R_W-1:0]  r_r;
        tca_pkg::t_ctag  r_tag;
        logic            r_neg;
        logic            r_vld;

        assign w_t  = {w_drem[k], w_dlow[k][Q_W-1]};
        assign w_ge = (w_t >= {1'b0, w_dr[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_dvld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= w_ge ? R_W'(w_t - {1'b0, w_dr[k]}) : R_W'(w_t);
                r_low <= {w_dlow[k][Q_W-2:0], 1'b0};
                r_q   <= {w_dq[k][Q_W-2:0], w_ge};
                r_r   <= w_dr[k];
                r_tag <= w_dtag[k];
                r_neg <= w_dneg[k];
            end
        end

        assign w_drem[k+1] = r_rem;
        assign w_dlow[k+1] = r_low;
        assign w_dq[k+1]   = r_q;
        assign w_dr[k+1]   = r_r;
        assign w_dtag[k+1] = r_tag;
        assign w_dneg[k+1] = r_neg;
        assign w_dvld[k+1] = r_vld;
    end

    // clamp, apply sign, square for the sine term
    logic [tca_pkg::QC_W-1:0]     w_qc;
    logic                         r_q_vld;
    logic signed [C_W-1:0]        r_q_c;
    logic [tca_pkg::YIN_W-1:0]    r_q_sq;
    logic                         r_q_sat;
    tca_pkg::t_ctag               r_q_tag;

    assign w_qc = (w_dq[Q_W] > Q_W'(tca_pkg::ONE_Q16)) ? tca_pkg::QC_W'(tca_pkg::ONE_Q16)
                                                        : tca_pkg::QC_W'(w_dq[Q_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld <= 1'b0;
        end else if (i_en) begin
            r_q_vld <= w_dvld[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q_c   <= w_dneg[Q_W] ? -$signed({1'b0, w_qc}) : $signed({1'b0, w_qc});
            r_q_sq  <= tca_pkg::YIN_W'(w_qc) * tca_pkg::YIN_W'(w_qc);
            r_q_sat <= w_qc[tca_pkg::QC_W-1];
            r_q_tag <= w_dtag[Q_W];
        end
    end

    logic [tca_pkg::YIN_W-1:0] w_yin;
    logic                      w_s2_vld;
    logic [tca_pkg::Y_W-1:0]   w_yv;
    logic [P2_W-1:0]           w_s2_pay;
    tca_pkg::t_ctag            w_s2_tag;
    logic                      w_s2_sat;
    logic signed [C_W-1:0]     w_s2_c;

    assign w_yin = (tca_pkg::YIN_W'(1) << 32) - r_q_sq;

    tca_isqrt #(
        .IN_W (tca_pkg::YIN_W),
        .PW   (P2_W)
    ) u_sqrt_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_q_vld),
        .i_val   (w_yin),
        .i_pay   ({r_q_tag, r_q_sat, r_q_c}),
        .o_valid (w_s2_vld),
        .o_root  (w_yv),
        .o_pay   (w_s2_pay)
    );

    assign w_s2_tag = w_s2_pay[P2_W-1 -: 2];
    assign w_s2_sat = w_s2_pay[C_W];
    assign w_s2_c   = $signed(w_s2_pay[C_W-1:0]);

    // vectoring CORDIC; negative cosines start rotated by a right angle
    logic signed [X_W-1:0] w_x [0:NSTEP];
    logic signed [X_W-1:0] w_y [0:NSTEP];
    logic signed [Z_W-1:0] w_z [0:NSTEP];
    tca_pkg::t_ctag        w_ktag [0:NSTEP];
    logic [NSTEP:0]        w_ksat;
    logic [NSTEP:0]        w_kneg;
    logic [NSTEP:0]        w_kvld;
    logic signed [X_W-1:0] r_i_x;
    logic signed [X_W-1:0] r_i_y;
    logic signed [Z_W-1:0] r_i_z;
    tca_pkg::t_ctag        r_i_tag;
    logic                  r_i_sat;
    logic                  r_i_neg;
    logic                  r_i_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_vld <= 1'b0;
        end else if (i_en) begin
            r_i_vld <= w_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!w_s2_c[C_W-1]) begin
                r_i_x <= X_W'(w_s2_c);
                r_i_y <= $signed(X_W'(w_yv));
                r_i_z <= '0;
            end else begin
                r_i_x <= $signed(X_W'(w_yv));
                r_i_y <= -X_W'(w_s2_c);
                r_i_z <= Z_W'(tca_pkg::DEG90_Q16);
            end
            r_i_tag <= w_s2_tag;
            r_i_sat <= w_s2_sat;
            r_i_neg <= w_s2_c[C_W-1];
        end
    end

    assign w_x[0]    = r_i_x;
    assign w_y[0]    = r_i_y;
    assign w_z[0]    = r_i_z;
    assign w_ktag[0] = r_i_tag;
    assign w_ksat[0] = r_i_sat;
    assign w_kneg[0] = r_i_neg;
    assign w_kvld[0] = r_i_vld;

    for (genvar i = 0; i < NSTEP; i++) begin : g_cordic
        logic signed [X_W-1:0] w_xs;
        logic signed [X_W-1:0] w_ys;
        logic                  w_ypos;
        logic signed [X_W-1:0] r_x;
        logic signed [X_W-1:0] r_y;
        logic signed [Z_W-1:0] r_z;
        tca_pkg::t_ctag        r_tag;
        logic                  r_sat;
        logic                  r_neg;
        logic                  r_vld;

        assign w_xs   = w_x[i] >>> i;
        assign w_ys   = w_y[i] >>> i;
        assign w_ypos = !w_y[i][X_W-1] && (w_y[i] != '0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_kvld[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x   <= w_ypos ? w_x[i] + w_ys : w_x[i] - w_ys;
                r_y   <= w_ypos ? w_y[i] - w_xs : w_y[i] + w_xs;
                r_z   <= w_ypos ? w_z[i] + tca_pkg::atan_q16(i)
                                : w_z[i] - tca_pkg::atan_q16(i);
                r_tag <= w_ktag[i];
                r_sat <= w_ksat[i];
                r_neg <= w_kneg[i];
            end
        end

        assign w_x[i+1]    = r_x;
        assign w_y[i+1]    = r_y;
        assign w_z[i+1]    = r_z;
        assign w_ktag[i+1] = r_tag;
        assign w_ksat[i+1] = r_sat;
        assign w_kneg[i+1] = r_neg;
        assign w_kvld[i+1] = r_vld;
    end

    // round half up to Q8.8, clamp, apply the special cases
    logic signed [Z_W-1:0]        w_zr;
    logic [tca_pkg::ANG_W-1:0]    w_ang;
    tca_pkg::t_ctag               w_ftag;

    assign w_zr   = (w_z[NSTEP] + Z_W'(128)) >>> 8;
    assign w_ftag = w_ktag[NSTEP];

    always_comb begin
        if (w_ftag.degen) begin
            w_ang = '0;
        end else if (w_ftag.right) begin
            w_ang = tca_pkg::ANG_W'(tca_pkg::ANGLE_RIGHT);
        end else if (w_ksat[NSTEP]) begin
            w_ang = w_kneg[NSTEP] ? tca_pkg::ANG_W'(tca_pkg::ANGLE_MAX) : '0;
        end else if (w_z[NSTEP] <= 0) begin
            w_ang = '0;
        end else if (w_zr > tca_pkg::ANGLE_MAX) begin
            w_ang = tca_pkg::ANG_W'(tca_pkg::ANGLE_MAX);
        end else begin
            w_ang = tca_pkg::ANG_W'(w_zr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= w_kvld[NSTEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_angle <= w_ang;
            o_degen <= w_ftag.degen;
        end
    end

endmodule

// File: hdl/tca_back.sv
module tca_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tca_pkg::t_sides             i_head,
    input  logic                        i_q_empty,
    output logic                        o_q_pop,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic [tca_pkg::ANG_W-1:0]   o_angle_one,
    output logic [tca_pkg::ANG_W-1:0]   o_angle_two,
    output logic [tca_pkg::ANG_W-1:0]   o_angle_three,
    output logic                        o_degenerate
);

    logic w_en;
    logic w_vld;

    // advance the whole pipeline unless a finished result is still waiting
    assign w_en    = !w_vld || i_pop;
    assign o_q_pop = w_en && !i_q_empty;
    assign o_empty = !w_vld;

    tca_corner u_one (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (!i_q_empty),
        .i_degen (i_head.degen),
        .i_opp   (i_head.la),
        .i_s1    (i_head.lb),
        .i_s2    (i_head.lc),
        .o_valid (w_vld),
        .o_degen (o_degenerate),
        .o_angle (o_angle_one)
    );

    tca_corner u_two (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (!i_q_empty),
        .i_degen (i_head.degen),
        .i_opp   (i_head.lb),
        .i_s1    (i_head.lc),
        .i_s2    (i_head.la),
        .o_valid (),
        .o_degen (),
        .o_angle (o_angle_two)
    );

    tca_corner u_three (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (!i_q_empty),
        .i_degen (i_head.degen),
        .i_opp   (i_head.lc),
        .i_s1    (i_head.la),
        .i_s2    (i_head.lb),
        .o_valid (),
        .o_degen (),
        .o_angle (o_angle_three)
    );

endmodule

// File: test/triangle_corner_angles_tb.sv
`timescale 1ns / 1ps

module triangle_corner_angles_tb;

    typedef logic signed [15:0] t_coord;

    typedef struct {
        t_coord c [9];
    } t_tri;

    typedef struct {
        logic [15:0] a1;
        logic [15:0] a2;
        logic [15:0] a3;
        logic        degen;
    } t_angles;

    localparam int ONE_Q16     = 65536;
    localparam int DEG90_Q16   = 5898240;
    localparam int ANGLE_MAX   = 46080;
    localparam int ANGLE_RIGHT = 23040;
    localparam int DIFF_LIMIT  = 32767;
    localparam int N_STEPS     = 17;
    localparam int N_ITEMS     = 700;

    localparam longint ATAN_Q16 [N_STEPS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_push = 1'b0;
    logic        i_pop = 1'b0;
    logic        o_full;
    logic        o_empty;
    t_coord      drv [9];
    logic [15:0] o_angle_one;
    logic [15:0] o_angle_two;
    logic [15:0] o_angle_three;
    logic        o_degenerate;
    logic        o_full_q = 1'b0;

    t_tri    tri_pending [$];
    t_angles angles_expected [$];
    int      errors = 0;
    int      n_checked = 0;
    int      n_degen = 0;
    int      push_idle_pct = 14;
    int      pop_idle_pct = 64;
    int      hold_off = 0;

    always #5 i_clk = ~i_clk;

    triangle_corner_angles u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_p1_x        (drv[0]),
        .i_p1_y        (drv[1]),
        .i_p1_z        (drv[2]),
        .i_p2_x        (drv[3]),
        .i_p2_y        (drv[4]),
        .i_p2_z        (drv[5]),
        .i_p3_x        (drv[6]),
        .i_p3_y        (drv[7]),
        .i_p3_z        (drv[8]),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_angle_one   (o_angle_one),
        .o_angle_two   (o_angle_two),
        .o_angle_three (o_angle_three),
        .o_degenerate  (o_degenerate)
    );

    function automatic longint fshift(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [15:0] arccos_deg(longint c);
        longint x, y, z, xs, ys, yv;
        longint unsigned q;
        if (c >= ONE_Q16) return 16'd0;
        if (c <= -ONE_Q16) return 16'(ANGLE_MAX);
        yv = longint'(int_sqrt((64'd1 << 32) - longint'(c * c)));
        if (c >= 0) begin
            x = c; y = yv; z = 0;
        end else begin
            x = yv; y = -c; z = DEG90_Q16;
        end
        for (int i = 0; i < N_STEPS; i++) begin
            xs = fshift(x, i);
            ys = fshift(y, i);
            if (y > 0) begin
                x = x + ys; y = y - xs; z += ATAN_Q16[i];
            end else begin
                x = x - ys; y = y + xs; z -= ATAN_Q16[i];
            end
        end
        if (z <= 0) return 16'd0;
        q = ($unsigned(z) + 128) >> 8;
        if (q > ANGLE_MAX) q = ANGLE_MAX;
        return 16'(q);
    endfunction

    function automatic logic [15:0] corner_angle(longint unsigned opp, longint unsigned s1,
                                                 longint unsigned s2);
        longint n;
        longint unsigned mag, p, r, q;
        int e;
        if (s1 == 0 || s2 == 0) return 16'(ANGLE_RIGHT);
        e = 0;
        n = longint'(s1) + longint'(s2) - longint'(opp);
        mag = n < 0 ? $unsigned(-n) : $unsigned(n);
        p = s1 * s2;
        while ((p >> 62) == 0) begin
            p <<= 2;
            e += 2;
        end
        r = int_sqrt(p);
        q = (((mag << (e / 2)) << 15) + r / 2) / r;
        if (q > ONE_Q16) q = ONE_Q16;
        return arccos_deg(n < 0 ? -longint'(q) : longint'(q));
    endfunction

    function automatic t_angles predict_angles(t_tri t);
        t_angles res;
        longint v [9];
        longint w [9];
        longint d;
        longint unsigned len [3];
        int s;
        bit fits;
        for (int k = 0; k < 9; k++) v[k] = longint'(t.c[k]);
        res = '{16'd0, 16'd0, 16'd0, 1'b0};
        for (int i = 0; i < 3; i++) begin
            if (v[i*3] == v[((i+1)%3)*3] && v[i*3+1] == v[((i+1)%3)*3+1]
                    && v[i*3+2] == v[((i+1)%3)*3+2]) res.degen = 1'b1;
        end
        if (res.degen) return res;
        s = 0;
        forever begin
            fits = 1'b1;
            for (int k = 0; k < 9; k++) w[k] = fshift(v[k], s);
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    d = w[i*3+k] - w[((i+1)%3)*3+k];
                    if (d > DIFF_LIMIT || d < -DIFF_LIMIT) fits = 1'b0;
                end
            end
            if (fits || s >= 40) break;
            s++;
        end
        // side i runs from vertex i to vertex i+1: P1P2, P2P3, P3P1
        for (int i = 0; i < 3; i++) begin
            len[i] = 0;
            for (int k = 0; k < 3; k++) begin
                d = w[((i+1)%3)*3+k] - w[i*3+k];
                len[i] += $unsigned(d * d);
            end
        end
        res.a1 = corner_angle(len[0], len[1], len[2]);
        res.a2 = corner_angle(len[1], len[2], len[0]);
        res.a3 = corner_angle(len[2], len[0], len[1]);
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    function automatic t_coord rand_coord(int range_sel);
        case (range_sel)
            0: return t_coord'($urandom);
            1: return t_coord'($signed($urandom_range(0, 64)) - 32);
            default: return t_coord'($signed($urandom_range(0, 4096)) - 2048);
        endcase
    endfunction

    function automatic t_tri make_tri(t_coord a0, t_coord a1, t_coord a2, t_coord b0,
                                      t_coord b1, t_coord b2, t_coord c0, t_coord c1,
                                      t_coord c2);
        t_tri t;
        t.c = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
        return t;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_push <= 1'b0;
        end else if (i_push && !o_full_q) begin
            void'(tri_pending.pop_front());
            offer_next();
        end else if (!i_push) begin
            offer_next();
        end
    end

    always @(posedge i_clk) begin
        o_full_q <= o_full;
        if (i_rst_n && i_push && !o_full) begin
            angles_expected.push_back(predict_angles(tri_pending[0]));
        end
    end

    task automatic offer_next();
        if (tri_pending.size() != 0 && $urandom_range(0, 99) >= push_idle_pct) begin
            i_push <= 1'b1;
            drv <= tri_pending[0].c;
        end else begin
            i_push <= 1'b0;
        end
    endtask

    // receiver
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_pop <= 1'b0;
        end else begin
            i_pop <= i_rst_n && ($urandom_range(0, 99) >= pop_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_angles want;
        if (i_rst_n && i_pop && !o_empty) begin
            if (angles_expected.size() == 0) begin
                report_mismatch("result with nothing expected", 0, 0);
            end else begin
                want = angles_expected.pop_front();
                n_checked++;
                if (want.degen) n_degen++;
                if (o_angle_one !== want.a1) report_mismatch("angle_one", o_angle_one, want.a1);
                if (o_angle_two !== want.a2) report_mismatch("angle_two", o_angle_two, want.a2);
                if (o_angle_three !== want.a3)
                    report_mismatch("angle_three", o_angle_three, want.a3);
                if (o_degenerate !== want.degen)
                    report_mismatch("degenerate", o_degenerate, want.degen);
            end
        end
    end

    initial begin
        t_tri t;
        int mode;
        for (int k = 0; k < 9; k++) drv[k] = '0;
        // directed: extremes, coincident vertices, collinear, right angle, vanishing side
        tri_pending.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
        tri_pending.push_back(make_tri(256, 0, 0, 256, 0, 0, 0, 256, 0));
        tri_pending.push_back(make_tri(0, 0, 0, 256, 0, 0, 256, 0, 0));
        tri_pending.push_back(make_tri(5, 6, 7, 0, 256, 0, 5, 6, 7));
        tri_pending.push_back(make_tri(0, 0, 0, 256, 0, 0, 0, 256, 0));
        tri_pending.push_back(make_tri(0, 0, 0, 256, 0, 0, 512, 0, 0));
        tri_pending.push_back(make_tri(0, 0, 0, 512, 0, 0, 256, 0, 0));
        tri_pending.push_back(make_tri(0, 0, 0, 256, 0, 0, 128, 222, 0));
        tri_pending.push_back(make_tri(-32768, -32768, -32768, 32767, 32767, 32767,
                                       -32768, 32767, 0));
        tri_pending.push_back(make_tri(-32768, 0, 0, 32767, 0, 0, 0, 32767, 0));
        tri_pending.push_back(make_tri(32767, 32767, 32767, -32768, -32768, -32768,
                                       32767, -32768, 32767));
        tri_pending.push_back(make_tri(-32768, 0, 0, 32767, 0, 0, -32767, 0, 0));
        tri_pending.push_back(make_tri(-32768, 0, 0, 32767, 0, 0, -32768, 1, 0));
        tri_pending.push_back(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
        tri_pending.push_back(make_tri(0, 0, 0, 1, 1, 1, -1, -1, -1));
        tri_pending.push_back(make_tri(-1, -1, -1, 0, 0, 0, 1, 0, 0));
        tri_pending.push_back(make_tri(0, 0, 0, 10000, 0, 1, 20000, 0, 0));
        tri_pending.push_back(make_tri(-21845, 21845, -21845, 21845, -21845, 21845,
                                       -32768, 32767, -1));
        repeat (11) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        for (int n = 0; n < N_ITEMS; n++) begin
            mode = $urandom_range(0, 9);
            for (int k = 0; k < 9; k++) t.c[k] = rand_coord(mode % 3);
            // occasionally make two vertices meet
            if (mode == 9) begin
                for (int k = 0; k < 3; k++) t.c[6 + k] = t.c[3 * $urandom_range(0, 1) + k];
            end
            tri_pending.push_back(t);
            if (n == 240) begin
                wait (tri_pending.size() < 10);
                @(negedge i_clk);
                hold_off = 300;
                push_idle_pct = 64;
                pop_idle_pct = 14;
            end else if (n == 470) begin
                wait (tri_pending.size() < 10);
                push_idle_pct = 0;
                pop_idle_pct = 0;
            end
        end
        wait (tri_pending.size() == 0 && angles_expected.size() == 0);
        repeat (120) @(posedge i_clk);
        $display("Checked %0d triangles, %0d degenerate, incl. extremes and a long output stall.",
                 n_checked, n_degen);
        if (errors == 0 && angles_expected.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

// File: triangle_corner_angles.f
hdl/tca_pkg.sv
hdl/tca_front.sv
hdl/tca_queue.sv
hdl/tca_isqrt.sv
hdl/tca_corner.sv
hdl/tca_back.sv
hdl/triangle_corner_angles.sv
test/triangle_corner_angles_tb.sv
